[rtl/ffha_pkg.sv]
`default_nettype none
package ffha_pkg;

	localparam int ADDR_BITS    = 24;
	localparam int SIZE_BITS    = 25;
	localparam int RSIZE_BITS   = 26;
	localparam int HEADER_BYTES = 32;
	localparam int ALIGN_BYTES  = 16;

	localparam logic [SIZE_BITS-1:0]  HEAP_SPAN   = 25'd16777216;
	localparam logic [SIZE_BITS-1:0]  LIMIT_RESET = 25'd16777216;
	localparam logic [RSIZE_BITS-1:0] ALIGN_MASK  = RSIZE_BITS'(ALIGN_BYTES - 1);

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NULL    = 2'd1;
	localparam logic [1:0] ST_FAIL    = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	typedef struct packed {
		logic                 opcode;
		logic [SIZE_BITS-1:0] req_size;
		logic [ADDR_BITS-1:0] release_addr;
	} in_beat_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] payload_addr;
		logic [1:0]           status;
	} out_beat_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [SIZE_BITS-1:0] bytes;
		logic                 free;
	} entry_t;

	typedef struct packed {
		logic start;
		logic search;
		logic cap_next;
		logic plan;
		logic shift;
		logic wr0;
		logic wr1;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic is_null;
		logic hit;
		logic miss;
		logic shift_done;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

[rtl/first_fit_heap_allocator_top.sv]
`default_nettype none
// The search walks the table one entry per cycle up to the hit; a split or merge then
//   walks only the tail past it.
// Requests are handled one at a time; the next beat can be taken in the cycle after the
//   result is loaded. A stalled result holds it off.
// Reset (arst_n low): table empty, heap top 0, heap_limit 16 MiB, no result pending.
// Table contents are not cleared; entries past the fill count are never read.
module first_fit_heap_allocator_top #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ffha_pkg::SIZE_BITS-1:0] cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ffha_pkg::in_beat_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ffha_pkg::out_beat_t            out_data
);
	import ffha_pkg::*;

	// Command and status between sequencer and datapath.
	dp_cmd_t    cmd;
	dp_status_t st;

	// Sequencer: accept a beat, search, plan, shift, write back, deliver.
	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// Datapath: block table memory, heap top, limit register and result register.
	// The result register holds a finished beat while the next request is taken.
	ffha_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cmd         (cmd),
		.st          (st)
	);

endmodule
`default_nettype wire

[rtl/ffha_ctrl.sv]
`default_nettype none
module ffha_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ffha_pkg::dp_status_t st,
	output ffha_pkg::dp_cmd_t    cmd
);
	import ffha_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_NEXT   = 3'd2;
	localparam logic [2:0] S_PLAN   = 3'd3;
	localparam logic [2:0] S_SHIFT  = 3'd4;
	localparam logic [2:0] S_WR0    = 3'd5;
	localparam logic [2:0] S_WR1    = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.start = in_valid;
				if (in_valid) state_nxt = S_SEARCH;
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				if (st.is_null || st.miss) state_nxt = S_PLAN;
				else if (st.hit) state_nxt = S_NEXT;
			end
			S_NEXT: begin
				cmd.cap_next = 1'b1;
				state_nxt    = S_PLAN;
			end
			S_PLAN: begin
				cmd.plan  = 1'b1;
				state_nxt = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (st.shift_done) state_nxt = S_WR0;
			end
			S_WR0: begin
				cmd.wr0   = 1'b1;
				state_nxt = S_WR1;
			end
			S_WR1: begin
				cmd.wr1   = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				cmd.load_out = st.out_free;
				if (st.out_free) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nxt;
	end

	assign in_stall = (state_q != S_IDLE);

endmodule
`default_nettype wire

[rtl/ffha_dp.sv]
`default_nettype none
module ffha_dp #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ffha_pkg::SIZE_BITS-1:0]      cfg_wr_data,
	input  ffha_pkg::in_beat_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ffha_pkg::out_beat_t                 out_data,
	input  ffha_pkg::dp_cmd_t                   cmd,
	output ffha_pkg::dp_status_t                st
);
	import ffha_pkg::*;

	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
	localparam logic [SIZE_BITS-1:0] H25 = SIZE_BITS'(HEADER_BYTES);
	localparam logic [ADDR_BITS-1:0] H24 = ADDR_BITS'(HEADER_BYTES);

	entry_t mem [MAX_BLOCKS];

	logic [SIZE_BITS-1:0]  limit_q;
	logic [CW-1:0]         count_q;
	logic [SIZE_BITS-1:0]  top_q;
	logic                  op_q;
	logic [RSIZE_BITS-1:0] size_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [CW-1:0]         ptr_q;
	logic [CW-1:0]         n_q;
	logic                  up_q;
	logic [1:0]            d_q;
	entry_t                rdata_s1;
	logic [CW-1:0]         idx_s1;
	logic                  rd_vld_s1;
	entry_t                hit_q, prev_q, next_q;
	logic [CW-1:0]         hit_idx_q;
	logic                  hit_found_q, next_ok_q;
	logic                  w0_en_q, w1_en_q;
	logic [CW-1:0]         w0_idx_q, w1_idx_q;
	entry_t                w0_q, w1_q;
	logic [CW-1:0]         cnt_plan_q;
	logic [SIZE_BITS-1:0]  top_plan_q;
	out_beat_t             res_q, out_q;
	logic                  out_vld_q;

	logic                  search_issue, shift_issue, issue, match;
	logic [RSIZE_BITS-1:0] size_round;
	logic [CW-1:0]         sh_dst;
	logic                  we;
	logic [CW-1:0]         wa;
	entry_t                wd;

	// plan signals
	logic [CW-1:0]         j1, j2, jm1;
	logic [SIZE_BITS-1:0]  ceil;
	logic                  split, full, grow_over, prev_free, next_free;
	logic                  p_w0_en, p_w1_en, p_up;
	logic [CW-1:0]         p_w0_idx, p_w1_idx, p_n, p_ptr, p_count;
	entry_t                p_w0, p_w1;
	logic [1:0]            p_d;
	logic [SIZE_BITS-1:0]  p_top;
	out_beat_t             p_res;

	assign size_round = ({1'b0, in_data.req_size} + ALIGN_MASK) & ~ALIGN_MASK;

	assign search_issue = cmd.search && (ptr_q < count_q);
	assign shift_issue  = cmd.shift && (n_q != '0);
	assign issue        = search_issue || shift_issue;

	always_comb begin
		if (op_q == OP_ALLOC)
			match = rdata_s1.free && ({1'b0, rdata_s1.bytes} >= size_q);
		else
			match = !rdata_s1.free &&
				(({1'b0, rdata_s1.start} + H25) == {1'b0, addr_q});
	end

	assign st.is_null    = (op_q == OP_ALLOC) ? (size_q == '0) : (addr_q == '0);
	assign st.hit        = rd_vld_s1 && match;
	assign st.miss       = !rd_vld_s1 && (ptr_q == count_q);
	assign st.shift_done = (n_q == '0) && !rd_vld_s1;
	assign st.out_free   = !out_vld_q || !out_stall;

	// Read side: one address per cycle, data registered.
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[ptr_q[IW-1:0]];
		idx_s1   <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_vld_s1 <= 1'b0;
		else rd_vld_s1 <= issue;
	end

	// Write side: shift writeback, then the planned entries.
	assign sh_dst = up_q ? (idx_s1 + CW'(1)) : (idx_s1 - CW'(d_q));

	always_comb begin
		we = 1'b0;
		wa = sh_dst;
		wd = rdata_s1;
		if (cmd.shift && rd_vld_s1) begin
			we = 1'b1;
		end else if (cmd.wr0 && w0_en_q) begin
			we = 1'b1;
			wa = w0_idx_q;
			wd = w0_q;
		end else if (cmd.wr1 && w1_en_q) begin
			we = 1'b1;
			wa = w1_idx_q;
			wd = w1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa[IW-1:0]] <= wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= in_data.opcode;
			size_q <= size_round;
			addr_q <= in_data.release_addr;
		end
		if (cmd.search && rd_vld_s1 && !match) prev_q <= rdata_s1;
		if (cmd.search && st.hit) begin
			hit_q     <= rdata_s1;
			hit_idx_q <= idx_s1;
		end
		if (cmd.cap_next) begin
			next_q    <= rdata_s1;
			next_ok_q <= rd_vld_s1;
		end
		if (cmd.plan) begin
			w0_en_q    <= p_w0_en;
			w0_idx_q   <= p_w0_idx;
			w0_q       <= p_w0;
			w1_en_q    <= p_w1_en;
			w1_idx_q   <= p_w1_idx;
			w1_q       <= p_w1;
			up_q       <= p_up;
			d_q        <= p_d;
			cnt_plan_q <= p_count;
			top_plan_q <= p_top;
			res_q      <= p_res;
		end
		if (cmd.load_out) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			n_q         <= '0;
			hit_found_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				ptr_q       <= '0;
				hit_found_q <= 1'b0;
			end else if (cmd.plan) begin
				ptr_q <= p_ptr;
				n_q   <= p_n;
			end else if (search_issue) begin
				ptr_q <= ptr_q + CW'(1);
			end else if (shift_issue) begin
				ptr_q <= up_q ? (ptr_q - CW'(1)) : (ptr_q + CW'(1));
				n_q   <= n_q - CW'(1);
			end
			if (cmd.search && st.hit) hit_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= LIMIT_RESET;
			count_q   <= '0;
			top_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wr_en) limit_q <= cfg_wr_data;
			if (cmd.wr1) begin
				count_q <= cnt_plan_q;
				top_q   <= top_plan_q;
			end
			if (cmd.load_out) out_vld_q <= 1'b1;
			else if (!out_stall) out_vld_q <= 1'b0;
		end
	end

	assign j1  = hit_idx_q + CW'(1);
	assign j2  = hit_idx_q + CW'(2);
	assign jm1 = hit_idx_q - CW'(1);

	assign ceil      = (limit_q > HEAP_SPAN) ? HEAP_SPAN : limit_q;
	assign full      = (count_q >= CNT_MAX);
	assign split     = ({2'b0, hit_q.bytes} >=
		({1'b0, size_q} + 27'(HEADER_BYTES + ALIGN_BYTES))) && !full;
	assign grow_over = ({2'b0, top_q} + 27'(HEADER_BYTES) + {1'b0, size_q}) >
		{2'b0, ceil};
	assign prev_free = (hit_idx_q != '0) && prev_q.free;
	assign next_free = next_ok_q && next_q.free;

	always_comb begin
		p_w0_en  = 1'b0;
		p_w0_idx = hit_idx_q;
		p_w0     = hit_q;
		p_w1_en  = 1'b0;
		p_w1_idx = j1;
		p_w1     = hit_q;
		p_n      = '0;
		p_ptr    = j1;
		p_up     = 1'b0;
		p_d      = 2'd1;
		p_count  = count_q;
		p_top    = top_q;
		p_res.payload_addr = '0;
		p_res.status       = ST_OK;
		if (st.is_null) begin
			p_res.status = ST_NULL;
		end else if (op_q == OP_ALLOC) begin
			if (hit_found_q) begin
				p_w0_en            = 1'b1;
				p_w0.free          = 1'b0;
				p_res.payload_addr = hit_q.start + H24;
				if (split) begin
					p_w0.bytes  = size_q[SIZE_BITS-1:0];
					p_w1_en     = 1'b1;
					p_w1.start  = hit_q.start + H24 + size_q[ADDR_BITS-1:0];
					p_w1.bytes  = hit_q.bytes - size_q[SIZE_BITS-1:0] - H25;
					p_w1.free   = 1'b1;
					p_n         = count_q - j1;
					p_ptr       = count_q - CW'(1);
					p_up        = 1'b1;
					p_count     = count_q + CW'(1);
				end
			end else if (full || grow_over) begin
				p_res.status = ST_FAIL;
			end else begin
				p_w0_en            = 1'b1;
				p_w0_idx           = count_q;
				p_w0.start         = top_q[ADDR_BITS-1:0];
				p_w0.bytes         = size_q[SIZE_BITS-1:0];
				p_w0.free          = 1'b0;
				p_count            = count_q + CW'(1);
				p_top              = top_q + H25 + size_q[SIZE_BITS-1:0];
				p_res.payload_addr = top_q[ADDR_BITS-1:0] + H24;
			end
		end else begin
			if (!hit_found_q) begin
				p_res.status = ST_IGNORED;
			end else begin
				p_w0_en   = 1'b1;
				p_w0.free = 1'b1;
				if (prev_free) begin
					p_w0_idx   = jm1;
					p_w0.start = prev_q.start;
					p_w0.bytes = prev_q.bytes + H25 + hit_q.bytes +
						(next_free ? (H25 + next_q.bytes) : '0);
				end else if (next_free) begin
					p_w0.bytes = hit_q.bytes + H25 + next_q.bytes;
				end
				if (prev_free && next_free) begin
					p_d     = 2'd2;
					p_ptr   = j2;
					p_n     = count_q - j2;
					p_count = count_q - CW'(2);
				end else if (prev_free) begin
					p_ptr   = j1;
					p_n     = count_q - j1;
					p_count = count_q - CW'(1);
				end else if (next_free) begin
					p_ptr   = j2;
					p_n     = count_q - j2;
					p_count = count_q - CW'(1);
				end
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX) else $error("entry count above table depth");
	a_shift_dst: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && rd_vld_s1) |-> (sh_dst < CNT_MAX))
		else $error("shift writeback outside table");
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= HEAP_SPAN) else $error("heap top beyond address space");
	a_release_used: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.plan && hit_found_q && (op_q == OP_RELEASE)) |-> !hit_q.free)
		else $error("release matched a free block");

endmodule
`default_nettype wire

[sim/testbench.sv]
`default_nettype none

// Heap model and expected-result queue for the allocator.
class heap_scoreboard;
	localparam int NBLK = 64;

	logic [23:0] blk_start [NBLK];
	logic [24:0] blk_bytes [NBLK];
	bit          blk_free  [NBLK];
	int          blk_count;
	longint      top;
	longint      limit;
	ffha_pkg::out_beat_t pending [$];
	int          errors;

	function new();
		blk_count = 0;
		top = 0;
		limit = 16777216;
		errors = 0;
	endfunction

	function void set_limit(logic [24:0] v);
		limit = v;
	endfunction

	function void drop_at(int idx);
		for (int k = idx; k + 1 < blk_count; k++) begin
			blk_start[k] = blk_start[k+1];
			blk_bytes[k] = blk_bytes[k+1];
			blk_free[k]  = blk_free[k+1];
		end
		blk_count--;
	endfunction

	function void put_at(int idx, logic [23:0] s, logic [24:0] b, bit f);
		for (int k = blk_count; k > idx; k--) begin
			blk_start[k] = blk_start[k-1];
			blk_bytes[k] = blk_bytes[k-1];
			blk_free[k]  = blk_free[k-1];
		end
		blk_start[idx] = s;
		blk_bytes[idx] = b;
		blk_free[idx]  = f;
		blk_count++;
	endfunction

	function void coalesce();
		int i;
		i = 0;
		while (i + 1 < blk_count) begin
			if (blk_free[i] && blk_free[i+1] &&
					longint'(blk_start[i]) + 32 + blk_bytes[i] == longint'(blk_start[i+1])) begin
				blk_bytes[i] = 25'(longint'(blk_bytes[i]) + 32 + blk_bytes[i+1]);
				drop_at(i + 1);
			end else
				i++;
		end
	endfunction

	function ffha_pkg::out_beat_t grant(logic [24:0] req);
		ffha_pkg::out_beat_t r;
		longint sz, cap, rest;
		r.payload_addr = '0;
		r.status = ffha_pkg::ST_OK;
		if (req == 0) begin
			r.status = ffha_pkg::ST_NULL;
			return r;
		end
		sz = ((longint'(req) + 15) / 16) * 16;
		for (int i = 0; i < blk_count; i++) begin
			if (blk_free[i] && blk_bytes[i] >= sz) begin
				blk_free[i] = 0;
				if (blk_bytes[i] >= sz + 48 && blk_count < NBLK) begin
					rest = blk_bytes[i] - sz - 32;
					blk_bytes[i] = 25'(sz);
					put_at(i + 1, 24'(longint'(blk_start[i]) + 32 + sz), 25'(rest), 1);
				end
				r.payload_addr = 24'(longint'(blk_start[i]) + 32);
				return r;
			end
		end
		cap = (limit > 16777216) ? 16777216 : limit;
		if (blk_count >= NBLK || top + 32 + sz > cap) begin
			r.status = ffha_pkg::ST_FAIL;
			return r;
		end
		put_at(blk_count, 24'(top), 25'(sz), 0);
		r.payload_addr = 24'(top + 32);
		top += 32 + sz;
		return r;
	endfunction

	function ffha_pkg::out_beat_t release_blk(logic [23:0] a);
		ffha_pkg::out_beat_t r;
		r.payload_addr = '0;
		r.status = ffha_pkg::ST_IGNORED;
		if (a == 0) begin
			r.status = ffha_pkg::ST_NULL;
			return r;
		end
		for (int i = 0; i < blk_count; i++) begin
			if (!blk_free[i] && longint'(blk_start[i]) + 32 == longint'(a)) begin
				blk_free[i] = 1;
				coalesce();
				r.status = ffha_pkg::ST_OK;
				return r;
			end
		end
		return r;
	endfunction

	// Note an accepted request beat and queue its expected result.
	function void note_request(ffha_pkg::in_beat_t b);
		if (b.opcode == ffha_pkg::OP_ALLOC)
			pending.push_back(grant(b.req_size));
		else
			pending.push_back(release_blk(b.release_addr));
	endfunction

	function void report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endfunction

	// Check one result beat against the oldest expectation.
	function void check_result(ffha_pkg::out_beat_t got);
		ffha_pkg::out_beat_t w;
		if (pending.size() == 0) begin
			report($sformatf("unexpected result addr=%h st=%0d", got.payload_addr, got.status));
			return;
		end
		w = pending.pop_front();
		if (got.payload_addr !== w.payload_addr)
			report($sformatf("payload_addr got %h want %h", got.payload_addr, w.payload_addr));
		if (got.status !== w.status)
			report($sformatf("status got %0d want %0d", got.status, w.status));
	endfunction

	// Live payload address for release stimulus, or 0 if none.
	function logic [23:0] pick_live();
		int live [$];
		for (int i = 0; i < blk_count; i++)
			if (!blk_free[i])
				live.push_back(i);
		if (live.size() == 0)
			return '0;
		return 24'(longint'(blk_start[live[$urandom_range(live.size() - 1)]]) + 32);
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ffha_pkg::*;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      cfg_wr_en = 0;
	logic [24:0] cfg_wr_data = '0;
	logic      in_valid = 0;
	logic      in_stall;
	in_beat_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 0;
	out_beat_t out_data;

	heap_scoreboard sb = new();
	bit stim_done = 0;
	bit idle_gaps = 1;
	int out_wait = 0;

	always #10 clk = ~clk;

	first_fit_heap_allocator_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Send one request beat; hold it until accepted, then drop valid.
	task automatic send_req(in_beat_t b);
		int gap;
		gap = idle_gaps ? $urandom_range(11) : 0;
		repeat (gap) @(posedge clk);
		in_valid <= 1;
		in_data  <= b;
		do @(posedge clk); while (in_stall);
		sb.note_request(b);
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_alloc(logic [24:0] sz);
		in_beat_t b;
		b.opcode = OP_ALLOC;
		b.req_size = sz;
		b.release_addr = 24'($urandom);
		send_req(b);
	endtask

	task automatic send_release(logic [23:0] a);
		in_beat_t b;
		b.opcode = OP_RELEASE;
		b.req_size = 25'($urandom);
		b.release_addr = a;
		send_req(b);
	endtask

	// Write heap_limit once all results are in and the block has settled.
	task automatic write_limit(logic [24:0] v);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		cfg_wr_en   <= 1;
		cfg_wr_data <= v;
		@(posedge clk);
		sb.set_limit(v);
		cfg_wr_en <= 0;
	endtask

	// Mostly small sizes, sometimes big or extreme ones.
	function automatic logic [24:0] rand_size();
		int r;
		r = $urandom_range(99);
		if (r < 70) return 25'($urandom_range(1, 200));
		if (r < 85) return 25'($urandom_range(1, 4096));
		if (r < 95) return 25'($urandom);
		return 25'(r[0] ? 25'h1FFFFFF : 25'd0);
	endfunction

	task automatic random_phase(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 50) send_alloc(rand_size());
			else if (r < 85) send_release(sb.pick_live());
			else if (r < 92) send_release(24'($urandom));
			else if (r < 96) send_release(sb.pick_live() + 24'd16);
			else send_release('0);
		end
	endtask

	// Consumer: check every accepted result beat, then hold off the next one
	// for a drawn number of valid cycles.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(out_data);
			out_wait = idle_gaps ? $urandom_range(11) : 0;
		end else if (out_valid && out_wait > 0)
			out_wait--;
		out_stall <= (out_wait != 0);
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: null cases, extremes, splits, merges, ignored frees.
		send_alloc(25'd0);
		send_release(24'd0);
		send_release(24'hFFFFFF);
		send_alloc(25'd1);
		send_alloc(25'd16);
		send_alloc(25'd17);
		send_alloc(25'd200);
		send_release(24'd32);
		send_release(24'd32);
		send_release(24'd80);
		send_alloc(25'd1);
		send_alloc(25'h1FFFFFF);
		send_alloc(25'd16777216);
		send_release(24'd144);
		send_alloc(25'd16);
		send_release(24'd33);
		random_phase(30);

		// Tight limit so growth fails often.
		write_limit(25'd0);
		send_alloc(25'd1);
		write_limit(25'd4096);
		random_phase(400);

		// Stretch with no idling on either side.
		idle_gaps = 0;
		write_limit(25'd16777216);
		random_phase(300);
		idle_gaps = 1;

		// Limit above the address span acts as the full span.
		write_limit(25'h1FFFFFF);
		random_phase(400);

		// Many small allocations to fill the table and skip splits.
		write_limit(25'd65536);
		for (int i = 0; i < 80; i++) send_alloc(25'($urandom_range(1, 64)));
		random_phase(620);

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule

`default_nettype wire
